// ===== hw/rtl/lsb_stego_stream_extractor_defines.svh =====
// ----------------------------------------------------------------------------
// lsb stego stream extractor assertion macros
// shared assertion shorthands for the checker
// ----------------------------------------------------------------------------
`ifndef LSB_STEGO_STREAM_EXTRACTOR_DEFINES_SVH
`define LSB_STEGO_STREAM_EXTRACTOR_DEFINES_SVH

// clocked assertion, off while reset is asserted
`define LSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked assertion that also holds during reset
`define LSE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hw/rtl/lse_pkg.sv =====
// ----------------------------------------------------------------------------
// lse_pkg
// types and constants of the lsb stego stream extractor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lse_pkg;

  // cover bytes skipped before the hidden bit stream starts
  localparam int unsigned HEADER_BYTES = 54;

  // parse phase
  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_MAGIC   = 3'd1,
    PH_EXT_LEN = 3'd2,
    PH_EXT     = 3'd3,
    PH_PAY_LEN = 3'd4,
    PH_PAY     = 3'd5,
    PH_HALT    = 3'd6
  } phase_e;

  // result kind
  typedef enum logic [2:0] {
    KIND_EXT       = 3'd0,
    KIND_PAY       = 3'd1,
    KIND_MAGIC_ERR = 3'd2,
    KIND_EXT_ERR   = 3'd3,
    KIND_EMPTY     = 3'd4
  } kind_e;

  // configuration register index
  typedef enum logic [1:0] {
    REG_MAGIC_CHARS  = 2'd0,
    REG_MAGIC_LENGTH = 2'd1,
    REG_MAX_EXT_LEN  = 2'd2
  } cfg_reg_e;

  // one result item
  typedef struct packed {
    kind_e      kind;
    logic [7:0] value;
    logic       last;
  } result_t;

  localparam logic [63:0] MAGIC_CHARS_RST  = 64'd10787;
  localparam logic [3:0]  MAGIC_LENGTH_RST = 4'd2;
  localparam logic [7:0]  MAX_EXT_LEN_RST  = 8'd8;
  localparam logic [3:0]  MAGIC_MAX        = 4'd8;

endpackage

// ===== hw/rtl/lsb_stego_stream_extractor.sv =====
// ----------------------------------------------------------------------------
// lsb_stego_stream_extractor
// skips the image header, gathers cover-byte lsbs msb first and parses the
// hidden frame: magic check, extension length and bytes, payload length and
// bytes
// ----------------------------------------------------------------------------
// channel   | direction | handshake                   | payload
// in        | sink      | in_valid_i / in_stall_o     | image_byte_i, frame_start_i
// out       | source    | out_valid_o / out_stall_i   | out_kind_o, out_value_o, out_last_o
// cfg       | sink      | cfg_valid_i / cfg_ready_o   | cfg_index_i, cfg_data_i
//
// one cover byte per cycle while in_stall_o is low; each result is registered into
// the output register. the parse state updates in the transfer cycle itself, and a
// two-entry output register with skid holds results while out_stall_i is high.
// in_stall_o rises only once the skid entry is full. rst_ni clears the parser
// to header skip and loads the register defaults; cfg_ready_o is always high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lsb_stego_stream_extractor (
  input  logic        clk_i,
  input  logic        rst_ni,
  // cover byte stream
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  image_byte_i,
  input  logic        frame_start_i,
  // result stream
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  out_kind_o,
  output logic [7:0]  out_value_o,
  output logic        out_last_o,
  // register writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  // configuration registers
  logic [63:0] magic_chars_q;
  logic [3:0]  magic_length_q;
  logic [7:0]  max_ext_len_q;

  // parse state
  lse_pkg::phase_e phase_q, phase_d;
  logic [31:0] rem_q, rem_d;
  logic [4:0]  bit_pos_q, bit_pos_d;
  logic [31:0] gather_q, gather_d;
  logic [3:0]  magic_pos_q, magic_pos_d;

  // output register and skid entry
  logic             out_valid_q;
  lse_pkg::result_t out_q;
  logic             skid_valid_q;
  lse_pkg::result_t skid_q;

  // working values for the current byte
  logic            accept;
  lse_pkg::phase_e s_phase;
  logic [31:0]     s_rem;
  logic [4:0]      s_bit_pos;
  logic [31:0]     s_gather;
  logic [3:0]      s_magic_pos;
  logic            hdr_skip;
  logic            live;
  logic [3:0]      magic_count;
  logic [31:0]     gather_sh;
  logic [4:0]      bit_pos_inc;
  logic            word_done;
  logic            byte_done;
  logic [31:0]     rem_dec;
  logic [3:0]      magic_pos_inc;
  logic [7:0]      magic_want;
  logic            ext_too_long;

  logic             res_valid;
  lse_pkg::result_t res;

  assign in_stall_o  = skid_valid_q;
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // register writes, indexes beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_chars_q  <= lse_pkg::MAGIC_CHARS_RST;
      magic_length_q <= lse_pkg::MAGIC_LENGTH_RST;
      max_ext_len_q  <= lse_pkg::MAX_EXT_LEN_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (lse_pkg::cfg_reg_e'(cfg_index_i))
        lse_pkg::REG_MAGIC_CHARS:  magic_chars_q  <= cfg_data_i;
        lse_pkg::REG_MAGIC_LENGTH: magic_length_q <= cfg_data_i[3:0];
        lse_pkg::REG_MAX_EXT_LEN:  max_ext_len_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign magic_count = (magic_length_q > lse_pkg::MAGIC_MAX) ? lse_pkg::MAGIC_MAX
                                                             : magic_length_q;

  // frame restart and header exit ahead of the bit gather
  always_comb begin
    s_phase     = phase_q;
    s_rem       = rem_q;
    s_bit_pos   = bit_pos_q;
    s_gather    = gather_q;
    s_magic_pos = magic_pos_q;
    if (frame_start_i) begin
      s_phase     = lse_pkg::PH_HEADER;
      s_rem       = '0;
      s_bit_pos   = '0;
      s_gather    = '0;
      s_magic_pos = '0;
    end
    hdr_skip = (s_phase == lse_pkg::PH_HEADER) &&
               (s_rem < 32'(lse_pkg::HEADER_BYTES));
    if (s_phase == lse_pkg::PH_HEADER && !hdr_skip) begin
      s_bit_pos   = '0;
      s_gather    = '0;
      s_magic_pos = '0;
      s_phase     = (magic_count == 4'd0) ? lse_pkg::PH_EXT_LEN : lse_pkg::PH_MAGIC;
    end
  end

  assign live          = !hdr_skip && (s_phase != lse_pkg::PH_HALT);
  assign gather_sh     = {s_gather[30:0], image_byte_i[0]};
  assign bit_pos_inc   = s_bit_pos + 5'd1;
  assign word_done     = (bit_pos_inc == 5'd0);
  assign byte_done     = (bit_pos_inc == 5'd8);
  assign rem_dec       = s_rem - 32'd1;
  assign magic_pos_inc = s_magic_pos + 4'd1;
  assign magic_want    = magic_chars_q[{s_magic_pos[2:0], 3'b000} +: 8];
  assign ext_too_long  = gather_sh > {24'd0, max_ext_len_q};

  // next parse state
  always_comb begin
    phase_d     = phase_q;
    rem_d       = rem_q;
    bit_pos_d   = bit_pos_q;
    gather_d    = gather_q;
    magic_pos_d = magic_pos_q;
    if (accept) begin
      phase_d     = s_phase;
      rem_d       = s_rem;
      bit_pos_d   = s_bit_pos;
      gather_d    = s_gather;
      magic_pos_d = s_magic_pos;
      if (hdr_skip) begin
        rem_d = s_rem + 32'd1;
      end else if (live) begin
        gather_d  = gather_sh;
        bit_pos_d = bit_pos_inc;
        case (s_phase)
          lse_pkg::PH_EXT_LEN: begin
            if (word_done) begin
              gather_d = '0;
              if (ext_too_long) begin
                phase_d = lse_pkg::PH_HALT;
              end else begin
                rem_d   = gather_sh;
                phase_d = (gather_sh == 32'd0) ? lse_pkg::PH_PAY_LEN : lse_pkg::PH_EXT;
              end
            end
          end
          lse_pkg::PH_PAY_LEN: begin
            if (word_done) begin
              gather_d = '0;
              if (gather_sh == 32'd0) begin
                phase_d = lse_pkg::PH_HALT;
              end else begin
                rem_d   = gather_sh;
                phase_d = lse_pkg::PH_PAY;
              end
            end
          end
          lse_pkg::PH_MAGIC: begin
            if (byte_done) begin
              bit_pos_d = '0;
              gather_d  = '0;
              if (gather_sh[7:0] != magic_want) begin
                phase_d = lse_pkg::PH_HALT;
              end else begin
                magic_pos_d = magic_pos_inc;
                if (magic_pos_inc >= magic_count) begin
                  phase_d = lse_pkg::PH_EXT_LEN;
                end
              end
            end
          end
          lse_pkg::PH_EXT: begin
            if (byte_done) begin
              bit_pos_d = '0;
              gather_d  = '0;
              rem_d     = rem_dec;
              if (rem_dec == 32'd0) begin
                phase_d = lse_pkg::PH_PAY_LEN;
              end
            end
          end
          lse_pkg::PH_PAY: begin
            if (byte_done) begin
              bit_pos_d = '0;
              gather_d  = '0;
              rem_d     = rem_dec;
              if (rem_dec == 32'd0) begin
                phase_d = lse_pkg::PH_HALT;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  // result for the current byte
  always_comb begin
    res_valid = 1'b0;
    res.kind  = lse_pkg::KIND_EXT;
    res.value = '0;
    res.last  = 1'b0;
    if (accept && live) begin
      case (s_phase)
        lse_pkg::PH_EXT_LEN: begin
          if (word_done && ext_too_long) begin
            res_valid = 1'b1;
            res.kind  = lse_pkg::KIND_EXT_ERR;
            res.last  = 1'b1;
          end
        end
        lse_pkg::PH_PAY_LEN: begin
          if (word_done && gather_sh == 32'd0) begin
            res_valid = 1'b1;
            res.kind  = lse_pkg::KIND_EMPTY;
            res.last  = 1'b1;
          end
        end
        lse_pkg::PH_MAGIC: begin
          if (byte_done && gather_sh[7:0] != magic_want) begin
            res_valid = 1'b1;
            res.kind  = lse_pkg::KIND_MAGIC_ERR;
            res.last  = 1'b1;
          end
        end
        lse_pkg::PH_EXT: begin
          if (byte_done) begin
            res_valid = 1'b1;
            res.kind  = lse_pkg::KIND_EXT;
            res.value = gather_sh[7:0];
          end
        end
        lse_pkg::PH_PAY: begin
          if (byte_done) begin
            res_valid = 1'b1;
            res.kind  = lse_pkg::KIND_PAY;
            res.value = gather_sh[7:0];
            res.last  = (rem_dec == 32'd0);
          end
        end
        default: ;
      endcase
    end
  end

  // parse state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= lse_pkg::PH_HEADER;
      rem_q       <= '0;
      bit_pos_q   <= '0;
      gather_q    <= '0;
      magic_pos_q <= '0;
    end else begin
      phase_q     <= phase_d;
      rem_q       <= rem_d;
      bit_pos_q   <= bit_pos_d;
      gather_q    <= gather_d;
      magic_pos_q <= magic_pos_d;
    end
  end

  // output register with skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  // output and skid payload
  always_ff @(posedge clk_i) begin
    if (!out_valid_q || !out_stall_i) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (res_valid) begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_q.kind;
  assign out_value_o = out_q.value;
  assign out_last_o  = out_q.last;

endmodule

// ===== hw/rtl/lse_checker.sv =====
// ----------------------------------------------------------------------------
// lse_checker
// port-level checks for the lsb stego stream extractor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lsb_stego_stream_extractor_defines.svh"

module lse_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  out_kind_o,
  input logic [7:0]  out_value_o,
  input logic        out_last_o
);

  logic err_kind;
  logic out_blocked;

  // result kinds that end a frame early
  assign err_kind    = (out_kind_o == lse_pkg::KIND_MAGIC_ERR) ||
                       (out_kind_o == lse_pkg::KIND_EXT_ERR) ||
                       (out_kind_o == lse_pkg::KIND_EMPTY);
  assign out_blocked = out_valid_o && out_stall_i;

  // a stalled result stays offered
  `LSE_ASSERT(a_out_hold, out_blocked |=> out_valid_o, "out valid dropped")

  // errors and empty payload always close the frame
  `LSE_ASSERT(a_err_last, out_valid_o && err_kind |-> out_last_o && out_value_o == 8'd0, "error result not last")

  // extension characters never carry last
  `LSE_ASSERT(a_ext_not_last, out_valid_o && out_kind_o == lse_pkg::KIND_EXT |-> !out_last_o, "extension marked last")

  // input can only stall after results backed up at the output
  `LSE_ASSERT_ALWAYS(a_stall_cause, $rose(in_stall_o) |-> $past(out_blocked), "input stall without output stall")

endmodule

bind lsb_stego_stream_extractor lse_checker u_lse_checker (.*);

// ===== tb/lse_frame_checker.sv =====
// ----------------------------------------------------------------------------
// lse_frame_checker
// watches the cover byte, result and register channels of the stream
// extractor, keeps its own copy of the frame parser and compares every result
// transfer with the oldest predicted result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lse_frame_checker
  import lse_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // cover byte stream
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  image_byte_i,
  input  logic        frame_start_i,
  // result stream
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [2:0]  out_kind_i,
  input  logic [7:0]  out_value_i,
  input  logic        out_last_i,
  // register writes
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  // status
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o
);

  // register copies
  logic [63:0] exp_magic;
  logic [3:0]  magic_len;
  logic [7:0]  ext_limit;

  // parser copy
  phase_e      parse_phase;
  logic [4:0]  bit_count;
  logic [31:0] bit_shift;
  logic [31:0] items_left;
  logic [3:0]  magic_index;

  result_t pending_results[$];
  int      fails;
  int      checked;

  function automatic void restart_parser();
    parse_phase = PH_HEADER;
    bit_count   = '0;
    bit_shift   = '0;
    items_left  = '0;
    magic_index = '0;
  endfunction

  // advance the parser by one cover byte, returns 1 when a result is due
  function automatic bit decode_cover_byte(input logic [7:0] cover_byte, input logic restart,
                                           output result_t res);
    logic [31:0] word;
    logic [3:0]  n_magic;
    res = '{kind: KIND_EXT, value: 8'h00, last: 1'b0};
    n_magic = (magic_len > MAGIC_MAX) ? MAGIC_MAX : magic_len;
    if (restart) restart_parser();

    // header skip, then open the bit stream
    if (parse_phase == PH_HEADER) begin
      if (items_left < HEADER_BYTES) begin
        items_left = items_left + 32'd1;
        return 1'b0;
      end
      bit_count   = '0;
      bit_shift   = '0;
      magic_index = '0;
      if (n_magic == 4'd0) parse_phase = PH_EXT_LEN;
      else parse_phase = PH_MAGIC;
    end
    if (parse_phase == PH_HALT) return 1'b0;

    bit_shift = {bit_shift[30:0], cover_byte[0]};
    bit_count = bit_count + 5'd1;

    // 32-bit length words
    if (parse_phase == PH_EXT_LEN || parse_phase == PH_PAY_LEN) begin
      if (bit_count != 5'd0) return 1'b0;
      word      = bit_shift;
      bit_shift = '0;
      if (parse_phase == PH_EXT_LEN) begin
        if (word > {24'd0, ext_limit}) begin
          parse_phase = PH_HALT;
          res = '{kind: KIND_EXT_ERR, value: 8'h00, last: 1'b1};
          return 1'b1;
        end
        items_left = word;
        if (word == 32'd0) parse_phase = PH_PAY_LEN;
        else parse_phase = PH_EXT;
        return 1'b0;
      end
      if (word == 32'd0) begin
        parse_phase = PH_HALT;
        res = '{kind: KIND_EMPTY, value: 8'h00, last: 1'b1};
        return 1'b1;
      end
      items_left  = word;
      parse_phase = PH_PAY;
      return 1'b0;
    end

    // byte-wide items
    if (bit_count != 5'd8) return 1'b0;
    word      = {24'd0, bit_shift[7:0]};
    bit_count = '0;
    bit_shift = '0;
    case (parse_phase)
      PH_MAGIC: begin
        if (word[7:0] != exp_magic[8*magic_index[2:0] +: 8]) begin
          parse_phase = PH_HALT;
          res = '{kind: KIND_MAGIC_ERR, value: 8'h00, last: 1'b1};
          return 1'b1;
        end
        magic_index = magic_index + 4'd1;
        if (magic_index >= n_magic) parse_phase = PH_EXT_LEN;
        return 1'b0;
      end
      PH_EXT: begin
        items_left = items_left - 32'd1;
        if (items_left == 32'd0) parse_phase = PH_PAY_LEN;
        res = '{kind: KIND_EXT, value: word[7:0], last: 1'b0};
        return 1'b1;
      end
      default: begin
        items_left = items_left - 32'd1;
        res = '{kind: KIND_PAY, value: word[7:0], last: 1'b0};
        if (items_left == 32'd0) begin
          parse_phase = PH_HALT;
          res.last    = 1'b1;
        end
        return 1'b1;
      end
    endcase
  endfunction

  // monitor: register writes, result compare, then prediction
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    result_t next_res;
    if (!rst_ni) begin
      exp_magic = MAGIC_CHARS_RST;
      magic_len = MAGIC_LENGTH_RST;
      ext_limit = MAX_EXT_LEN_RST;
      restart_parser();
      pending_results.delete();
      fails        = 0;
      checked      = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_MAGIC_CHARS:  exp_magic = cfg_data_i;
          REG_MAGIC_LENGTH: magic_len = cfg_data_i[3:0];
          REG_MAX_EXT_LEN:  ext_limit = cfg_data_i[7:0];
          default: ;
        endcase
      end

      if (out_valid_i && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result transfer: kind %0d value %0d last %0d",
                 out_kind_i, out_value_i, out_last_i);
          fails++;
        end else begin
          want = pending_results.pop_front();
          checked++;
          if (out_kind_i !== want.kind) begin
            $error("out_kind mismatch: expected %0d actual %0d", want.kind, out_kind_i);
            fails++;
          end
          if (out_value_i !== want.value) begin
            $error("out_value mismatch: expected %0d actual %0d", want.value, out_value_i);
            fails++;
          end
          if (out_last_i !== want.last) begin
            $error("out_last mismatch: expected %0d actual %0d", want.last, out_last_i);
            fails++;
          end
        end
      end

      if (in_valid_i && !in_stall_i) begin
        if (decode_cover_byte(image_byte_i, frame_start_i, next_res))
          pending_results.push_back(next_res);
      end

      fail_count_o <= fails;
      pending_o    <= pending_results.size();
      checked_o    <= checked;
    end
  end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// drives cover image streams into the lsb stego stream extractor: directed
// frames for the error and empty cases, then random frames, broken frames and
// noise under several register settings, with random gaps and stalls on both
// channels; a separate checker predicts and compares every result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import lse_pkg::*;

  localparam int          STALL_LIMIT  = 2000;  // cycles with no transfer at all
  localparam int          HOLD_CYCLES  = 400;   // long receiver hold-off
  localparam int          DRAIN_CYCLES = 8;
  localparam int          PHASE_BYTES  = 100;
  localparam int          NUM_PHASES   = 4;
  localparam logic [1:0]  REG_UNMAPPED = 2'd3;   // no register behind this index

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic        in_stall_o;
  logic [7:0]  image_byte_i  = 8'h00;
  logic        frame_start_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i   = 1'b0;
  logic [2:0]  out_kind_o;
  logic [7:0]  out_value_o;
  logic        out_last_o;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i   = REG_MAGIC_CHARS;
  logic [63:0] cfg_data_i    = '0;

  int fail_count;
  int pending;
  int checked;
  int quiet_cycles = 0;

  // stimulus bookkeeping
  logic [63:0] cfg_magic     = MAGIC_CHARS_RST;
  logic [3:0]  cfg_magic_len = MAGIC_LENGTH_RST;
  logic [7:0]  cfg_ext_limit = MAX_EXT_LEN_RST;
  bit          sender_gaps   = 1'b1;
  bit          hold_req      = 1'b0;
  int          bytes_sent    = 0;
  int          frame_count   = 0;
  int          settings_used = 1;
  bit          frame_bits[$];

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  lsb_stego_stream_extractor DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .image_byte_i  (image_byte_i),
    .frame_start_i (frame_start_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_kind_o    (out_kind_o),
    .out_value_o   (out_value_o),
    .out_last_o    (out_last_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  lse_frame_checker frame_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .image_byte_i  (image_byte_i),
    .frame_start_i (frame_start_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_kind_i    (out_kind_o),
    .out_value_i   (out_value_o),
    .out_last_i    (out_last_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .checked_o     (checked)
  );

  // mostly short gaps, now and then a long one
  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // hidden bits go out msb first
  function automatic void push_field(input logic [31:0] val, input int nbits);
    for (int i = nbits - 1; i >= 0; i--) frame_bits.push_back(val[i]);
  endfunction

  task automatic send_byte(input logic [7:0] data, input logic restart);
    int n;
    n = sender_gaps ? gap_length() : 0;
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    image_byte_i  <= data;
    frame_start_i <= restart;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  // build one frame against the current registers and stream it out
  task automatic send_frame(input logic [31:0] ext_len, input logic [31:0] pay_len,
                            input int bad_char, input logic restart,
                            input int keep_bits, input int tail);
    int         n_magic;
    logic [7:0] ch;
    frame_bits.delete();
    n_magic = (cfg_magic_len > MAGIC_MAX) ? MAGIC_MAX : cfg_magic_len;
    for (int k = 0; k < n_magic; k++) begin
      ch = cfg_magic[8*k +: 8];
      if (k == bad_char) ch = ch ^ 8'($urandom_range(1, 255));
      push_field({24'd0, ch}, 8);
    end
    push_field(ext_len, 32);
    if (ext_len <= {24'd0, cfg_ext_limit}) begin
      repeat (ext_len) push_field($urandom, 8);
      push_field(pay_len, 32);
      // huge lengths only get a few bytes before the stream is cut
      repeat ((pay_len <= 32'd256) ? pay_len : 32'd5) push_field($urandom, 8);
    end
    if (keep_bits >= 0)
      while (frame_bits.size() > keep_bits) void'(frame_bits.pop_back());
    send_byte(8'($urandom), restart);
    repeat (HEADER_BYTES - 1) send_byte(8'($urandom), 1'b0);
    foreach (frame_bits[i]) send_byte({7'($urandom), frame_bits[i]}, 1'b0);
    repeat (tail) send_byte(8'($urandom), 1'b0);
    frame_count++;
  endtask

  task automatic random_frame();
    int          pick;
    int          n_magic;
    int          bad;
    int          keep;
    logic [31:0] ext_len;
    logic [31:0] pay_len;
    pick    = $urandom_range(0, 99);
    n_magic = (cfg_magic_len > MAGIC_MAX) ? MAGIC_MAX : cfg_magic_len;
    bad     = -1;
    keep    = -1;
    ext_len = $urandom_range(0, (cfg_ext_limit < 6) ? cfg_ext_limit : 6);
    if (cfg_ext_limit <= 16 && $urandom_range(0, 7) == 0) ext_len = cfg_ext_limit;
    pay_len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 30) : $urandom_range(1, 8);
    sender_gaps = ($urandom_range(0, 3) != 0);
    if (pick >= 90) begin
      // noise with stray frame starts
      repeat ($urandom_range(8, 60)) send_byte(8'($urandom), $urandom_range(0, 15) == 0);
      return;
    end
    if (pick >= 80) begin
      // huge payload length, cut off by the next frame start
      pay_len = $urandom | 32'h0000_0200;
      if ($urandom_range(0, 1) == 1) keep = $urandom_range(0, 200);
    end else if (pick >= 70) begin
      if ($urandom_range(0, 1) == 1) ext_len = cfg_ext_limit + $urandom_range(1, 4);
      else ext_len = {1'b1, 31'($urandom)};
    end else if (pick >= 60 && n_magic > 0) begin
      bad = $urandom_range(0, n_magic - 1);
    end
    send_frame(ext_len, pay_len, bad, 1'b1, keep, $urandom_range(0, 4));
  endtask

  // let every predicted result come out, then let the block settle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic apply_config(input logic [63:0] magic, input logic [3:0] mlen,
                              input logic [7:0] limit);
    wait_idle();
    // unmapped index, must leave every register alone
    write_reg(REG_UNMAPPED, {$urandom, $urandom});
    write_reg(REG_MAGIC_CHARS, magic);
    write_reg(REG_MAGIC_LENGTH, {$urandom, 28'($urandom), mlen});
    write_reg(REG_MAX_EXT_LEN, {$urandom, 24'($urandom), limit});
    cfg_valid_i   <= 1'b0;
    cfg_magic     = magic;
    cfg_magic_len = mlen;
    cfg_ext_limit = limit;
    settings_used++;
  endtask

  // transfer watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  // result receiver: random stalls, quiet stretches, one long hold-off on request
  initial begin
    int n;
    forever begin
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end
      n = gap_length();
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      repeat ($urandom_range(1, ($urandom_range(0, 9) == 0) ? 150 : 6)) @(posedge clk_i);
    end
  end

  // stimulus and verdict
  initial begin
    int start_bytes;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed frames on the reset register values
    send_frame(32'd2, 32'd3, -1, 1'b0, -1, 2);          // first frame without frame start
    send_frame(32'd1, 32'd2, 1, 1'b1, -1, 3);           // second magic char wrong
    send_frame(32'd0, 32'd1, 0, 1'b1, -1, 1);           // first magic char wrong
    send_frame(32'd9, 32'd1, -1, 1'b1, -1, 2);          // extension one over the limit
    send_frame(32'hFFFF_FFFF, 32'd1, -1, 1'b1, -1, 1);  // all-ones extension length
    send_frame(32'd0, 32'd0, -1, 1'b1, -1, 2);          // no extension, empty payload
    send_frame(32'd8, 32'd1, -1, 1'b1, -1, 0);          // extension at the limit
    send_frame(32'd3, 32'd5, -1, 1'b1, 16 + 32 + 12, 0); // cut inside the extension
    send_frame(32'd1, 32'd4, -1, 1'b1, 16 + 32 + 8 + 40, 0); // cut inside the payload

    // random part over several register settings
    for (int phase_idx = 0; phase_idx < NUM_PHASES; phase_idx++) begin
      case (phase_idx)
        0: apply_config('1, 4'd8, 8'd255);
        1: apply_config('0, 4'd0, 8'd0);
        2: apply_config({$urandom, $urandom}, 4'd15, 8'($urandom));
        default: apply_config({$urandom, $urandom}, 4'($urandom_range(0, 15)),
                              ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 12))
                                                          : 8'($urandom));
      endcase
      if (phase_idx == 0) begin
        // long receiver hold-off while bytes keep coming, fills the block up
        hold_req    = 1'b1;
        sender_gaps = 1'b0;
        send_frame(32'd4, 32'd8, -1, 1'b1, -1, 0);
      end
      start_bytes = bytes_sent;
      while (bytes_sent - start_bytes < PHASE_BYTES) random_frame();
    end

    wait_idle();
    if (pending != 0) $error("%0d predicted results never arrived", pending);
    $display("covered %0d cover bytes in %0d frames plus noise, %0d register settings",
             bytes_sent, frame_count, settings_used);
    $display("%0d results compared, %0d mismatches", checked, fail_count);
    if (fail_count == 0 && pending == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/lse_pkg.sv
hw/rtl/lsb_stego_stream_extractor.sv
hw/rtl/lse_checker.sv
tb/lse_frame_checker.sv
tb/testbench.sv
